// ----- sv/etc2_pkg.sv -----
// ETC2/EAC RGBA8 block decoder: shared types, constants and table functions.
// No dependencies.
package etc2_pkg;

    localparam logic [1:0] ALPHA_OPAQUE = 2'd0;
    localparam logic [1:0] ALPHA_PUNCH  = 2'd1;
    localparam logic [1:0] ALPHA_EAC    = 2'd2;

    typedef enum logic [2:0] {
        KIND_INDIV,
        KIND_DIFF,
        KIND_T,
        KIND_H,
        KIND_PLANAR
    } kind_t;

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] pixel_index;
        logic       last_pixel;
    } out_item_t;

    function automatic logic [7:0] mod_lookup(input logic [2:0] tbl);
        logic [7:0] m;
        case (tbl)
            3'd0: m = 8'd2;
            3'd1: m = 8'd5;
            3'd2: m = 8'd9;
            3'd3: m = 8'd13;
            3'd4: m = 8'd18;
            3'd5: m = 8'd24;
            3'd6: m = 8'd33;
            default: m = 8'd47;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] mod_large(input logic [2:0] tbl);
        logic [7:0] m;
        case (tbl)
            3'd0: m = 8'd8;
            3'd1: m = 8'd17;
            3'd2: m = 8'd29;
            3'd3: m = 8'd42;
            3'd4: m = 8'd60;
            3'd5: m = 8'd80;
            3'd6: m = 8'd106;
            default: m = 8'd183;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] dist_lookup(input logic [2:0] i);
        logic [6:0] d;
        case (i)
            3'd0: d = 7'd3;
            3'd1: d = 7'd6;
            3'd2: d = 7'd11;
            3'd3: d = 7'd16;
            3'd4: d = 7'd23;
            3'd5: d = 7'd32;
            3'd6: d = 7'd41;
            default: d = 7'd64;
        endcase
        return d;
    endfunction

    // EAC modifier, signed 5 bits
    function automatic logic signed [4:0] eac_lookup(input logic [3:0] row,
                                                     input logic [2:0] i);
        logic [39:0] r;
        case (row)
            4'd0:  r = {-5'sd3, -5'sd6, -5'sd9, -5'sd15, 5'sd2, 5'sd5, 5'sd8, 5'sd14};
            4'd1:  r = {-5'sd3, -5'sd7, -5'sd10, -5'sd13, 5'sd2, 5'sd6, 5'sd9, 5'sd12};
            4'd2:  r = {-5'sd2, -5'sd5, -5'sd8, -5'sd13, 5'sd1, 5'sd4, 5'sd7, 5'sd12};
            4'd3:  r = {-5'sd2, -5'sd4, -5'sd6, -5'sd13, 5'sd1, 5'sd3, 5'sd5, 5'sd12};
            4'd4:  r = {-5'sd3, -5'sd6, -5'sd8, -5'sd12, 5'sd2, 5'sd5, 5'sd7, 5'sd11};
            4'd5:  r = {-5'sd3, -5'sd7, -5'sd9, -5'sd11, 5'sd2, 5'sd6, 5'sd8, 5'sd10};
            4'd6:  r = {-5'sd4, -5'sd7, -5'sd8, -5'sd11, 5'sd3, 5'sd6, 5'sd7, 5'sd10};
            4'd7:  r = {-5'sd3, -5'sd5, -5'sd8, -5'sd11, 5'sd2, 5'sd4, 5'sd7, 5'sd10};
            4'd8:  r = {-5'sd2, -5'sd6, -5'sd8, -5'sd10, 5'sd1, 5'sd5, 5'sd7, 5'sd9};
            4'd9:  r = {-5'sd2, -5'sd5, -5'sd8, -5'sd10, 5'sd1, 5'sd4, 5'sd7, 5'sd9};
            4'd10: r = {-5'sd2, -5'sd4, -5'sd8, -5'sd10, 5'sd1, 5'sd3, 5'sd7, 5'sd9};
            4'd11: r = {-5'sd2, -5'sd5, -5'sd7, -5'sd10, 5'sd1, 5'sd4, 5'sd6, 5'sd9};
            4'd12: r = {-5'sd3, -5'sd4, -5'sd7, -5'sd10, 5'sd2, 5'sd3, 5'sd6, 5'sd9};
            4'd13: r = {-5'sd1, -5'sd2, -5'sd3, -5'sd10, 5'sd0, 5'sd1, 5'sd2, 5'sd9};
            4'd14: r = {-5'sd4, -5'sd6, -5'sd8, -5'sd9, 5'sd3, 5'sd5, 5'sd7, 5'sd8};
            default: r = {-5'sd3, -5'sd5, -5'sd7, -5'sd9, 5'sd2, 5'sd4, 5'sd6, 5'sd8};
        endcase
        return r[(7 - i) * 5 +: 5];
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] widen7(input logic [6:0] v);
        return {v, v[6]};
    endfunction

    function automatic logic [7:0] sat8(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/etc2_rgba_block_decoder_unit.sv -----
// ETC2/EAC RGBA8 block decoder top level.
// Each accepted block is registered into stage 1; its pixels then pass through the result register
// to out_item, one a cycle while out_stall is low. The next block is taken at the edge that moves
// pixel 15 into the result register, so a stall on the output also holds off the next block.
// Reset (rst_n, async low) clears valid flags, pixel counter and alpha_mode to opaque.
// Depends on etc2_pkg.
module etc2_rgba_block_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  etc2_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output etc2_pkg::out_item_t out_item
);
    import etc2_pkg::*;

    logic [1:0] alpha_mode_reg;

    // stage 1: decoded block
    logic        blk_valid_reg;
    logic [63:0] c_reg;
    logic [63:0] a_reg;
    kind_t       kind_reg;
    logic        pt_clear_reg;
    logic        use_eac_reg;
    logic [7:0]  base_r_reg [2];
    logic [7:0]  base_g_reg [2];
    logic [7:0]  base_b_reg [2];
    logic [7:0]  pr_reg [4];
    logic [7:0]  pg_reg [4];
    logic [7:0]  pb_reg [4];
    logic [3:0]  pix_reg;

    // stage 2: result register
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic out_take;
    logic pix_adv;
    logic blk_load;

    assign out_take = !out_valid_reg || !out_stall;
    assign pix_adv  = blk_valid_reg && out_take;
    assign blk_load = !blk_valid_reg || (pix_adv && pix_reg == 4'd15);
    assign in_stall = !blk_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= ALPHA_OPAQUE;
        end
        else if (cfg_we)
        begin
            alpha_mode_reg <= cfg_data;
        end
    end

    // ---- block decode (stage 1 next values) ----
    logic [63:0] c;
    logic        punch;
    logic        opq;
    logic [4:0]  br, bg, bb;
    logic signed [6:0] sr, sg, sb;
    kind_t       kind_next;
    logic [7:0]  base_r_next [2];
    logic [7:0]  base_g_next [2];
    logic [7:0]  base_b_next [2];
    logic [7:0]  pr_next [4];
    logic [7:0]  pg_next [4];
    logic [7:0]  pb_next [4];
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    logic [6:0]  dt, dh;

    always_comb
    begin
        c     = in_item.color_block;
        punch = (alpha_mode_reg == ALPHA_PUNCH);
        opq   = c[33];
        br    = c[63:59];
        bg    = c[55:51];
        bb    = c[47:43];
        sr    = $signed({2'b00, br}) + $signed({{4{c[58]}}, c[58:56]});
        sg    = $signed({2'b00, bg}) + $signed({{4{c[50]}}, c[50:48]});
        sb    = $signed({2'b00, bb}) + $signed({{4{c[42]}}, c[42:40]});

        if (!punch && !opq)
            kind_next = KIND_INDIV;
        else if (sr < 0 || sr > 7'sd31)
            kind_next = KIND_T;
        else if (sg < 0 || sg > 7'sd31)
            kind_next = KIND_H;
        else if (sb < 0 || sb > 7'sd31)
            kind_next = KIND_PLANAR;
        else
            kind_next = KIND_DIFF;

        if (kind_next == KIND_INDIV)
        begin
            base_r_next[0] = widen4(c[63:60]); base_r_next[1] = widen4(c[59:56]);
            base_g_next[0] = widen4(c[55:52]); base_g_next[1] = widen4(c[51:48]);
            base_b_next[0] = widen4(c[47:44]); base_b_next[1] = widen4(c[43:40]);
        end
        else
        begin
            base_r_next[0] = widen5(br); base_r_next[1] = widen5(sr[4:0]);
            base_g_next[0] = widen5(bg); base_g_next[1] = widen5(sg[4:0]);
            base_b_next[0] = widen5(bb); base_b_next[1] = widen5(sb[4:0]);
        end

        // T mode
        dt = dist_lookup({c[35:34], c[32]});
        // H mode
        r0 = widen4(c[62:59]);
        g0 = widen4({c[58:56], c[52]});
        b0 = widen4({c[51], c[49:47]});
        r1 = widen4(c[46:43]);
        g1 = widen4(c[42:39]);
        b1 = widen4(c[38:35]);
        dh = dist_lookup({c[34], c[32], ({r0, g0, b0} >= {r1, g1, b1})});

        if (kind_next == KIND_T)
        begin
            pr_next[0] = widen4({c[60:59], c[57:56]});
            pg_next[0] = widen4(c[55:52]);
            pb_next[0] = widen4(c[51:48]);
            pr_next[2] = widen4(c[47:44]);
            pg_next[2] = widen4(c[43:40]);
            pb_next[2] = widen4(c[39:36]);
            pr_next[1] = sat8($signed({4'd0, pr_next[2]}) + $signed({5'd0, dt}));
            pg_next[1] = sat8($signed({4'd0, pg_next[2]}) + $signed({5'd0, dt}));
            pb_next[1] = sat8($signed({4'd0, pb_next[2]}) + $signed({5'd0, dt}));
            pr_next[3] = sat8($signed({4'd0, pr_next[2]}) - $signed({5'd0, dt}));
            pg_next[3] = sat8($signed({4'd0, pg_next[2]}) - $signed({5'd0, dt}));
            pb_next[3] = sat8($signed({4'd0, pb_next[2]}) - $signed({5'd0, dt}));
        end
        else
        begin
            pr_next[0] = sat8($signed({4'd0, r0}) + $signed({5'd0, dh}));
            pg_next[0] = sat8($signed({4'd0, g0}) + $signed({5'd0, dh}));
            pb_next[0] = sat8($signed({4'd0, b0}) + $signed({5'd0, dh}));
            pr_next[1] = sat8($signed({4'd0, r0}) - $signed({5'd0, dh}));
            pg_next[1] = sat8($signed({4'd0, g0}) - $signed({5'd0, dh}));
            pb_next[1] = sat8($signed({4'd0, b0}) - $signed({5'd0, dh}));
            pr_next[2] = sat8($signed({4'd0, r1}) + $signed({5'd0, dh}));
            pg_next[2] = sat8($signed({4'd0, g1}) + $signed({5'd0, dh}));
            pb_next[2] = sat8($signed({4'd0, b1}) + $signed({5'd0, dh}));
            pr_next[3] = sat8($signed({4'd0, r1}) - $signed({5'd0, dh}));
            pg_next[3] = sat8($signed({4'd0, g1}) - $signed({5'd0, dh}));
            pb_next[3] = sat8($signed({4'd0, b1}) - $signed({5'd0, dh}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            pix_reg       <= 4'd0;
        end
        else
        begin
            if (blk_load)
            begin
                blk_valid_reg <= in_valid;
                pix_reg       <= 4'd0;
            end
            else if (pix_adv)
            begin
                pix_reg <= pix_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_load && in_valid)
        begin
            c_reg        <= c;
            a_reg        <= in_item.alpha_block;
            kind_reg     <= kind_next;
            pt_clear_reg <= punch && !opq;
            use_eac_reg  <= (alpha_mode_reg == ALPHA_EAC);
            for (int i = 0; i < 2; i++)
            begin
                base_r_reg[i] <= base_r_next[i];
                base_g_reg[i] <= base_g_next[i];
                base_b_reg[i] <= base_b_next[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                pr_reg[i] <= pr_next[i];
                pg_reg[i] <= pg_next[i];
                pb_reg[i] <= pb_next[i];
            end
        end
    end

    // ---- per-pixel decode (stage 2 next values) ----
    logic [1:0]  x, y;
    logic [3:0]  k;
    logic [1:0]  idx;
    logic        sub;
    logic [2:0]  tbl;
    logic [7:0]  mag;
    logic signed [8:0] m;
    logic [7:0]  ro, go, bo, rh, gh, bh, rv, gv, bv;
    logic [7:0]  red_n, green_n, blue_n, alpha_n;
    logic [2:0]  ai;
    logic signed [11:0] eac_sum;
    logic [5:0]  ai_lo;

    function automatic logic [7:0] planar_ch(input logic [7:0] o, input logic [7:0] h,
                                             input logic [7:0] v, input logic [1:0] px,
                                             input logic [1:0] py);
        logic signed [11:0] u;
        u = $signed({4'd0, h}) * $signed({10'd0, px})
          - $signed({4'd0, o}) * $signed({10'd0, px})
          + $signed({4'd0, v}) * $signed({10'd0, py})
          - $signed({4'd0, o}) * $signed({10'd0, py})
          + $signed({2'd0, o, 2'd0}) + 12'sd2;
        return sat8(u >>> 2);
    endfunction

    always_comb
    begin
        x   = pix_reg[1:0];
        y   = pix_reg[3:2];
        k   = {x, y};
        idx = {c_reg[16 + k], c_reg[k]};
        sub = (c_reg[32] ? y : x) >= 2'd2;
        tbl = sub ? c_reg[36:34] : c_reg[39:37];
        mag = idx[0] ? mod_large(tbl) : mod_lookup(tbl);
        if (pt_clear_reg && idx == 2'd0)
            m = 9'sd0;
        else if (idx[1])
            m = -$signed({1'b0, mag});
        else
            m = $signed({1'b0, mag});

        ro = widen6(c_reg[62:57]);
        go = widen7({c_reg[56], c_reg[54:49]});
        bo = widen6({c_reg[48], c_reg[44:43], c_reg[41:39]});
        rh = widen6({c_reg[38:34], c_reg[32]});
        gh = widen7(c_reg[31:25]);
        bh = widen6(c_reg[24:19]);
        rv = widen6(c_reg[18:13]);
        gv = widen7(c_reg[12:6]);
        bv = widen6(c_reg[5:0]);

        if (kind_reg == KIND_PLANAR)
        begin
            red_n   = planar_ch(ro, rh, rv, x, y);
            green_n = planar_ch(go, gh, gv, x, y);
            blue_n  = planar_ch(bo, bh, bv, x, y);
            alpha_n = 8'd255;
        end
        else if (pt_clear_reg && idx == 2'd2)
        begin
            red_n = 8'd0; green_n = 8'd0; blue_n = 8'd0; alpha_n = 8'd0;
        end
        else if (kind_reg == KIND_INDIV || kind_reg == KIND_DIFF)
        begin
            red_n   = sat8($signed({4'd0, base_r_reg[sub]}) + 12'(m));
            green_n = sat8($signed({4'd0, base_g_reg[sub]}) + 12'(m));
            blue_n  = sat8($signed({4'd0, base_b_reg[sub]}) + 12'(m));
            alpha_n = 8'd255;
        end
        else
        begin
            red_n   = pr_reg[idx];
            green_n = pg_reg[idx];
            blue_n  = pb_reg[idx];
            alpha_n = 8'd255;
        end

        // alpha index bits sit at 45-3k
        ai_lo   = 6'd45 - 6'(k) * 6'd3;
        ai      = a_reg[ai_lo +: 3];
        eac_sum = $signed({4'd0, a_reg[63:56]})
                + $signed({8'd0, a_reg[55:52]}) * 12'(eac_lookup(a_reg[51:48], ai));
        if (use_eac_reg)
            alpha_n = sat8(eac_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= blk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_adv)
        begin
            out_reg.red         <= red_n;
            out_reg.green       <= green_n;
            out_reg.blue        <= blue_n;
            out_reg.alpha       <= alpha_n;
            out_reg.pixel_index <= pix_reg;
            out_reg.last_pixel  <= (pix_reg == 4'd15);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    // output held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    // pixel order follows counter
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_item.pixel_index != 4'd15 && out_valid_reg
        && blk_valid_reg |=> !out_valid || out_item.pixel_index == $past(pix_reg))
        else $error("pixel order broken");
    // a new block only after the last pixel leaves stage 1
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid_reg && pix_reg != 4'd15 |-> in_stall)
        else $error("block taken mid-sequence");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.last_pixel == (out_item.pixel_index == 4'd15))
        else $error("last flag mismatch");
`endif

endmodule

// ----- bench/etc2_rgba_block_decoder_unit_tb.sv -----
// Testbench for etc2_rgba_block_decoder_unit: random and directed blocks, scoreboard check.
// Depends on etc2_pkg and the decoder RTL.
`timescale 1ns / 100ps

module etc2_rgba_block_decoder_unit_tb;
    import etc2_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    class pixel_scoreboard;
        out_item_t pending[$];
        logic [1:0] amode;
        int errors;

        function new();
            amode = ALPHA_OPAQUE;
            errors = 0;
        endfunction

        static function int bits(logic [63:0] w, int lo, int n);
            return int'((w >> lo) & ((64'd1 << n) - 1));
        endfunction

        static function int expand(int v, int n);
            int u;
            u = v & ((1 << n) - 1);
            return ((u << (8 - n)) | (u >> (2 * n - 8))) & 255;
        endfunction

        static function int clamp8(int v);
            return v < 0 ? 0 : (v > 255 ? 255 : v);
        endfunction

        static function int sx3(int v);
            return (v & 4) ? v - 8 : v;
        endfunction

        static function int modv(int tbl, int idx);
            int lo[8];
            int hi[8];
            lo = '{2, 5, 9, 13, 18, 24, 33, 47};
            hi = '{8, 17, 29, 42, 60, 80, 106, 183};
            case (idx)
                0: return lo[tbl];
                1: return hi[tbl];
                2: return -lo[tbl];
                default: return -hi[tbl];
            endcase
        endfunction

        static function int distv(int i);
            int t[8];
            t = '{3, 6, 11, 16, 23, 32, 41, 64};
            return t[i];
        endfunction

        static function int eacv(int row, int i);
            int t[16][8];
            t = '{'{-3, -6, -9, -15, 2, 5, 8, 14}, '{-3, -7, -10, -13, 2, 6, 9, 12},
                  '{-2, -5, -8, -13, 1, 4, 7, 12}, '{-2, -4, -6, -13, 1, 3, 5, 12},
                  '{-3, -6, -8, -12, 2, 5, 7, 11}, '{-3, -7, -9, -11, 2, 6, 8, 10},
                  '{-4, -7, -8, -11, 3, 6, 7, 10}, '{-3, -5, -8, -11, 2, 4, 7, 10},
                  '{-2, -6, -8, -10, 1, 5, 7, 9}, '{-2, -5, -8, -10, 1, 4, 7, 9},
                  '{-2, -4, -8, -10, 1, 3, 7, 9}, '{-2, -5, -7, -10, 1, 4, 6, 9},
                  '{-3, -4, -7, -10, 2, 3, 6, 9}, '{-1, -2, -3, -10, 0, 1, 2, 9},
                  '{-4, -6, -8, -9, 3, 5, 7, 8}, '{-3, -5, -7, -9, 2, 4, 6, 8}};
            return t[row][i];
        endfunction

        // decode one block into sixteen expected pixels
        function void note_block(in_item_t blk);
            logic [63:0] c;
            logic [63:0] a;
            bit punch;
            bit clear;
            kind_t kind;
            int br, bg, bb, sr, sg, sb, d;
            int r0, g0, b0, r1, g1, b1;
            int base_r[2], base_g[2], base_b[2];
            int pr[4], pg[4], pb[4];
            int x, y, k, idx, sub, tbl, m, r, g, b, al;
            int ro, go, bo, rh, gh, bh, rv, gv, bv, ur, ug, ub;
            out_item_t px;
            c = blk.color_block;
            a = blk.alpha_block;
            punch = (amode == ALPHA_PUNCH);
            clear = punch && bits(c, 33, 1) == 0;
            br = bits(c, 59, 5);
            bg = bits(c, 51, 5);
            bb = bits(c, 43, 5);
            sr = br + sx3(bits(c, 56, 3));
            sg = bg + sx3(bits(c, 48, 3));
            sb = bb + sx3(bits(c, 40, 3));
            if (!punch && bits(c, 33, 1) == 0) kind = KIND_INDIV;
            else if (sr < 0 || sr > 31) kind = KIND_T;
            else if (sg < 0 || sg > 31) kind = KIND_H;
            else if (sb < 0 || sb > 31) kind = KIND_PLANAR;
            else kind = KIND_DIFF;

            if (kind == KIND_INDIV)
            begin
                base_r = '{expand(bits(c, 60, 4), 4), expand(bits(c, 56, 4), 4)};
                base_g = '{expand(bits(c, 52, 4), 4), expand(bits(c, 48, 4), 4)};
                base_b = '{expand(bits(c, 44, 4), 4), expand(bits(c, 40, 4), 4)};
            end
            else if (kind == KIND_DIFF)
            begin
                base_r = '{expand(br, 5), expand(sr, 5)};
                base_g = '{expand(bg, 5), expand(sg, 5)};
                base_b = '{expand(bb, 5), expand(sb, 5)};
            end
            else if (kind == KIND_T)
            begin
                d = distv((bits(c, 34, 2) << 1) | bits(c, 32, 1));
                pr[0] = expand((bits(c, 59, 2) << 2) | bits(c, 56, 2), 4);
                pg[0] = expand(bits(c, 52, 4), 4);
                pb[0] = expand(bits(c, 48, 4), 4);
                pr[2] = expand(bits(c, 44, 4), 4);
                pg[2] = expand(bits(c, 40, 4), 4);
                pb[2] = expand(bits(c, 36, 4), 4);
                pr[1] = clamp8(pr[2] + d); pg[1] = clamp8(pg[2] + d); pb[1] = clamp8(pb[2] + d);
                pr[3] = clamp8(pr[2] - d); pg[3] = clamp8(pg[2] - d); pb[3] = clamp8(pb[2] - d);
            end
            else if (kind == KIND_H)
            begin
                r0 = expand(bits(c, 59, 4), 4);
                g0 = expand((bits(c, 56, 3) << 1) | bits(c, 52, 1), 4);
                b0 = expand((bits(c, 51, 1) << 3) | bits(c, 47, 3), 4);
                r1 = expand(bits(c, 43, 4), 4);
                g1 = expand(bits(c, 39, 4), 4);
                b1 = expand(bits(c, 35, 4), 4);
                d = distv((bits(c, 34, 1) << 2) | (bits(c, 32, 1) << 1)
                          | ((((r0 << 16) | (g0 << 8) | b0) >= ((r1 << 16) | (g1 << 8) | b1))
                             ? 1 : 0));
                pr[0] = clamp8(r0 + d); pg[0] = clamp8(g0 + d); pb[0] = clamp8(b0 + d);
                pr[1] = clamp8(r0 - d); pg[1] = clamp8(g0 - d); pb[1] = clamp8(b0 - d);
                pr[2] = clamp8(r1 + d); pg[2] = clamp8(g1 + d); pb[2] = clamp8(b1 + d);
                pr[3] = clamp8(r1 - d); pg[3] = clamp8(g1 - d); pb[3] = clamp8(b1 - d);
            end

            for (int p = 0; p < 16; p++)
            begin
                x = p & 3;
                y = p >> 2;
                k = x * 4 + y;  // index bits are column-major
                idx = (bits(c, 16 + k, 1) << 1) | bits(c, k, 1);
                al = 255;
                if (kind == KIND_PLANAR)
                begin
                    ro = expand(bits(c, 57, 6), 6);
                    go = expand((bits(c, 56, 1) << 6) | bits(c, 49, 6), 7);
                    bo = expand((bits(c, 48, 1) << 5) | (bits(c, 43, 2) << 3)
                                | bits(c, 39, 3), 6);
                    rh = expand((bits(c, 34, 5) << 1) | bits(c, 32, 1), 6);
                    gh = expand(bits(c, 25, 7), 7);
                    bh = expand(bits(c, 19, 6), 6);
                    rv = expand(bits(c, 13, 6), 6);
                    gv = expand(bits(c, 6, 7), 7);
                    bv = expand(bits(c, 0, 6), 6);
                    ur = x * (rh - ro) + y * (rv - ro) + 4 * ro + 2;
                    ug = x * (gh - go) + y * (gv - go) + 4 * go + 2;
                    ub = x * (bh - bo) + y * (bv - bo) + 4 * bo + 2;
                    r = ur < 0 ? 0 : clamp8(ur / 4);
                    g = ug < 0 ? 0 : clamp8(ug / 4);
                    b = ub < 0 ? 0 : clamp8(ub / 4);
                end
                else if (clear && idx == 2)
                begin
                    r = 0; g = 0; b = 0; al = 0;
                end
                else if (kind == KIND_INDIV || kind == KIND_DIFF)
                begin
                    sub = (((bits(c, 32, 1) != 0) ? y : x) >= 2) ? 1 : 0;
                    tbl = sub ? bits(c, 34, 3) : bits(c, 37, 3);
                    m = (clear && idx == 0) ? 0 : modv(tbl, idx);
                    r = clamp8(base_r[sub] + m);
                    g = clamp8(base_g[sub] + m);
                    b = clamp8(base_b[sub] + m);
                end
                else
                begin
                    r = pr[idx]; g = pg[idx]; b = pb[idx];
                end
                if (amode == ALPHA_EAC)
                    al = clamp8(bits(a, 56, 8) + bits(a, 52, 4)
                                * eacv(bits(a, 48, 4), bits(a, 45 - 3 * k, 3)));
                px.red = r[7:0];
                px.green = g[7:0];
                px.blue = b[7:0];
                px.alpha = al[7:0];
                px.pixel_index = p[3:0];
                px.last_pixel = (p == 15);
                pending.push_back(px);
            end
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected pixel %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red)
            begin
                $display("%0t: red exp %0d got %0d", $time, want.red, got.red); errors++;
            end
            if (got.green !== want.green)
            begin
                $display("%0t: green exp %0d got %0d", $time, want.green, got.green); errors++;
            end
            if (got.blue !== want.blue)
            begin
                $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue); errors++;
            end
            if (got.alpha !== want.alpha)
            begin
                $display("%0t: alpha exp %0d got %0d", $time, want.alpha, got.alpha); errors++;
            end
            if (got.pixel_index !== want.pixel_index)
            begin
                $display("%0t: pixel_index exp %0d got %0d", $time, want.pixel_index,
                         got.pixel_index);
                errors++;
            end
            if (got.last_pixel !== want.last_pixel)
            begin
                $display("%0t: last_pixel exp %0d got %0d", $time, want.last_pixel,
                         got.last_pixel);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;

    pixel_scoreboard sb;
    int idle_cycles;
    int stall_style;

    etc2_rgba_block_decoder_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // receiver: stall pattern switches between none, light and heavy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_style = 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0) stall_style = $urandom_range(0, 2);
            case (stall_style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) sb.check_pixel(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog timeout", $time);
                $display("** etc2_rgba_block_decoder_unit: FAILED **");
                $finish;
            end
        end
    end

    int burst_left;

    // the caller always follows with another send_block or a drain in the same step,
    // which lowers in_valid when a burst ends
    task automatic send_block(logic [63:0] c, logic [63:0] a);
        in_item_t blk;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        blk.color_block = c;
        blk.alpha_block = a;
        in_valid <= 1'b1;
        in_item <= blk;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_block(blk);
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_alpha_mode(logic [1:0] m);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.amode = m;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // color word steered toward a given mode
    function automatic logic [63:0] shaped_color(int which);
        logic [63:0] c;
        c = rand64();
        case (which)
            0: c[33] = 1'b0;
            1:
            begin
                c[33] = 1'b1; c[63:59] = 5'd31; c[58:56] = 3'd1;         // T
            end
            2:
            begin
                c[33] = 1'b1; c[63:59] = 5'd10; c[58:56] = 3'd0;
                c[55:51] = 5'd0; c[50:48] = 3'd4;                         // H
            end
            3:
            begin
                c[33] = 1'b1; c[63:59] = 5'd10; c[58:56] = 3'd0;
                c[55:51] = 5'd10; c[50:48] = 3'd0;
                c[47:43] = 5'd30; c[42:40] = 3'd3;                        // planar
            end
            default:
            begin
                c[33] = 1'b1; c[63:59] = 5'd10; c[58:56] = 3'd0;
                c[55:51] = 5'd10; c[50:48] = 3'd0;
                c[47:43] = 5'd10; c[42:40] = 3'd0;                        // differential
            end
        endcase
        return c;
    endfunction

    initial
    begin
        logic [1:0] modes[8];
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_data = ALPHA_OPAQUE;
        in_valid = 0;
        in_item = '0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and each mode per alpha setting
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        for (int mi = 0; mi < 3; mi++)
        begin
            set_alpha_mode(mi[1:0]);
            for (int w = 0; w < 5; w++) send_block(shaped_color(w), rand64());
        end
        // EAC: multiplier zero, saturating base, all-zero and all-one
        send_block(shaped_color(4), {8'd200, 4'd0, 52'h0});
        send_block(shaped_color(1), {8'd255, 4'd15, 4'd0, 48'hFFFF_FFFF_FFFF});
        send_block(shaped_color(2), {8'd0, 4'd15, 4'd0, 48'h0});
        set_alpha_mode(2'd3);
        send_block(shaped_color(0), rand64());
        send_block(shaped_color(4), rand64());
        // punch-through with every index 2 or 3, then every index 0
        set_alpha_mode(ALPHA_PUNCH);
        send_block({shaped_color(4)} & ~64'h2_0000_0000 | 64'hFFFF_0000, 64'h0);
        send_block(shaped_color(1) & ~64'h2_FFFF_FFFF, 64'h0);

        modes = '{ALPHA_EAC, ALPHA_OPAQUE, ALPHA_PUNCH, 2'd3, ALPHA_EAC, ALPHA_PUNCH,
                  ALPHA_OPAQUE, ALPHA_EAC};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_alpha_mode(modes[ph]);
            for (int n = 0; n < 30; n++)
            begin
                if ($urandom_range(0, 3) == 0) send_block(rand64(), rand64());
                else send_block(shaped_color($urandom_range(0, 4)), rand64());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** etc2_rgba_block_decoder_unit: PASSED **");
        else
            $display("** etc2_rgba_block_decoder_unit: FAILED **");
        $finish;
    end

endmodule
